FILE: hw/rtl/b7s_pkg.sv
// b7s_pkg: widths, digit codes and the seven-segment table for the display decoder
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package b7s_pkg;

  // field widths
  localparam int unsigned ValueW = 16;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned SegW   = 7;

  // largest value that the four digits can show, and the width that holds it
  localparam logic [ValueW-1:0] MaxValue = 16'd9999;
  localparam int unsigned BinW   = 14;
  localparam int unsigned NumDig = 4;
  localparam int unsigned BcdW   = NumDig * CodeW;

  // digit codes
  localparam logic [CodeW-1:0] BlankCode = 4'd10;
  localparam logic [CodeW-1:0] DigitFive = 4'd5;
  localparam logic [CodeW-1:0] DigitAdj  = 4'd3;
  localparam logic [CodeW-1:0] DigitZero = 4'd0;

  // work item carried along the conversion chain
  typedef struct packed {
    logic [BcdW-1:0] bcd;
    logic [BinW-1:0] bin;
    logic            clamped;
  } b7s_work_t;

  // segment pattern for a digit code, bit 0 = a .. bit 6 = g, blank is all off
  function automatic logic [SegW-1:0] seg_decode(input logic [CodeW-1:0] code);
    logic [SegW-1:0] segs;
    case (code)
      4'd0:    segs = 7'h3F;
      4'd1:    segs = 7'h06;
      4'd2:    segs = 7'h5B;
      4'd3:    segs = 7'h4F;
      4'd4:    segs = 7'h66;
      4'd5:    segs = 7'h6D;
      4'd6:    segs = 7'h7D;
      4'd7:    segs = 7'h07;
      4'd8:    segs = 7'h7F;
      4'd9:    segs = 7'h6F;
      default: segs = 7'h00;
    endcase
    return segs;
  endfunction

endpackage

FILE: hw/rtl/b7s_ifs.sv
// b7s_in_if / b7s_out_if: valid/ready channels of the display decoder
// depends on b7s_pkg for the field widths
`timescale 1ns / 1ps

interface b7s_in_if
  import b7s_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface b7s_out_if
  import b7s_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] units_code;
  logic [CodeW-1:0] tens_code;
  logic [CodeW-1:0] hundreds_code;
  logic [CodeW-1:0] thousands_code;
  logic [SegW-1:0]  units_segs;
  logic [SegW-1:0]  tens_segs;
  logic [SegW-1:0]  hundreds_segs;
  logic [SegW-1:0]  thousands_segs;
  logic             clamped;

  modport source (
    output valid, output units_code, output tens_code, output hundreds_code,
    output thousands_code, output units_segs, output tens_segs,
    output hundreds_segs, output thousands_segs, output clamped, input ready
  );
  modport sink (
    input valid, input units_code, input tens_code, input hundreds_code,
    input thousands_code, input units_segs, input tens_segs,
    input hundreds_segs, input thousands_segs, input clamped, output ready
  );
endinterface

FILE: hw/rtl/binary_to_seven_segment_display_top.sv
// binary_to_seven_segment_display_top: a 16-bit value in, four blanked digit codes and
// their seven-segment patterns out. An accepted transaction passes through 14 cells (one
// per binary bit) and then the blanking/decode register. Throughput is one transaction per
// cycle while the output is not stalled; each stage moves on when empty or drained. Reset
// clears only the stage valid bits; no clearing pass is needed. Depends on b7s_pkg,
// b7s_ifs, b7s_dd_cell, b7s_seg_stage
`timescale 1ns / 1ps

module binary_to_seven_segment_display_top
  import b7s_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  b7s_in_if.sink    in_i,
  b7s_out_if.source out_o
);

  logic      valid_c [BinW+1];
  logic      ready_c [BinW+1];
  b7s_work_t data_c  [BinW+1];
  logic      over;

  // clamp to 9999 and load the chain
  assign over              = (in_i.value_in > MaxValue);
  assign valid_c[0]        = in_i.valid;
  assign data_c[0].bcd     = '0;
  assign data_c[0].bin     = over ? MaxValue[BinW-1:0] : in_i.value_in[BinW-1:0];
  assign data_c[0].clamped = over;
  assign in_i.ready        = ready_c[0];

  // one conversion cell per binary bit
  for (genvar k = 0; k < BinW; k++) begin : g_cell
    b7s_dd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[k]),
      .data_i  (data_c[k]),
      .ready_o (ready_c[k]),
      .valid_o (valid_c[k+1]),
      .data_o  (data_c[k+1]),
      .ready_i (ready_c[k+1])
    );
  end

  // blanking, decode and output register
  b7s_seg_stage u_seg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_c[BinW]),
    .data_i  (data_c[BinW]),
    .ready_o (ready_c[BinW]),
    .out_o   (out_o)
  );

endmodule

FILE: hw/rtl/b7s_dd_cell.sv
// b7s_dd_cell: one shift-and-add-3 step of the binary to bcd conversion, registered
// depends on b7s_pkg for the work item type
`timescale 1ns / 1ps

module b7s_dd_cell
  import b7s_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  b7s_work_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  output b7s_work_t data_o,
  input  logic      ready_i
);

  logic      valid_q;
  b7s_work_t data_q;
  b7s_work_t data_d;
  logic [BcdW-1:0] adj;

  // stage moves when empty or when the next one takes its transaction
  assign ready_o = !valid_q || ready_i;

  // add 3 to every digit of 5 or more, then shift in the next binary bit
  always_comb begin
    for (int d = 0; d < NumDig; d++) begin
      if (data_i.bcd[d*CodeW +: CodeW] >= DigitFive) begin
        adj[d*CodeW +: CodeW] = data_i.bcd[d*CodeW +: CodeW] + DigitAdj;
      end else begin
        adj[d*CodeW +: CodeW] = data_i.bcd[d*CodeW +: CodeW];
      end
    end
    data_d.bcd     = {adj[BcdW-2:0], data_i.bin[BinW-1]};
    data_d.bin     = {data_i.bin[BinW-2:0], 1'b0};
    data_d.clamped = data_i.clamped;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/b7s_seg_stage.sv
// b7s_seg_stage: leading-zero blanking, segment decode and the output register
// depends on b7s_pkg and b7s_out_if
`timescale 1ns / 1ps

module b7s_seg_stage
  import b7s_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  b7s_work_t data_i,
  output logic      ready_o,
  b7s_out_if.source out_o
);

  logic             valid_q;
  logic [CodeW-1:0] code_d [NumDig];
  logic [CodeW-1:0] code_q [NumDig];
  logic [SegW-1:0]  segs_q [NumDig];
  logic             clamped_q;
  logic             blank_th;
  logic             blank_hu;
  logic             blank_te;

  assign ready_o = !valid_q || out_o.ready;

  // blank zeros from the thousands down; units always shows
  always_comb begin
    blank_th = (data_i.bcd[3*CodeW +: CodeW] == DigitZero);
    blank_hu = blank_th && (data_i.bcd[2*CodeW +: CodeW] == DigitZero);
    blank_te = blank_hu && (data_i.bcd[1*CodeW +: CodeW] == DigitZero);
    code_d[0] = data_i.bcd[0 +: CodeW];
    code_d[1] = blank_te ? BlankCode : data_i.bcd[1*CodeW +: CodeW];
    code_d[2] = blank_hu ? BlankCode : data_i.bcd[2*CodeW +: CodeW];
    code_d[3] = blank_th ? BlankCode : data_i.bcd[3*CodeW +: CodeW];
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      for (int d = 0; d < NumDig; d++) begin
        code_q[d] <= code_d[d];
        segs_q[d] <= seg_decode(code_d[d]);
      end
      clamped_q <= data_i.clamped;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.units_code     = code_q[0];
  assign out_o.tens_code      = code_q[1];
  assign out_o.hundreds_code  = code_q[2];
  assign out_o.thousands_code = code_q[3];
  assign out_o.units_segs     = segs_q[0];
  assign out_o.tens_segs      = segs_q[1];
  assign out_o.hundreds_segs  = segs_q[2];
  assign out_o.thousands_segs = segs_q[3];
  assign out_o.clamped        = clamped_q;

  // a clamped value shows 9 in the thousands and units digits
  a_clamp_nines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && clamped_q |-> code_q[3] == 4'd9 && code_q[0] == 4'd9)
    else $error("clamped result is not 9999");

  // the units digit is never blanked
  a_units_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> code_q[0] <= 4'd9)
    else $error("units digit out of range");

  // a blanked tens digit needs the upper digits blanked too
  a_blank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && code_q[1] == BlankCode |-> code_q[2] == BlankCode && code_q[3] == BlankCode)
    else $error("inner zero blanked");

  // a blanked hundreds digit drives no segments, and the tens segments match the tens code
  a_blank_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && code_q[2] == BlankCode |-> segs_q[2] == '0 && segs_q[1] == seg_decode(code_q[1]))
    else $error("blanked hundreds digit lights segments");

endmodule
